/* design/cft_pkg.sv */
`timescale 1ns / 1ps

package cft_pkg;

    // Width of the internal saturating counters; ports carry the low 32 bits.
    localparam int COUNT_WIDTH = 32;
    localparam int PORT_COUNT_WIDTH = 32;

    // Field mode register codes
    localparam logic [1:0] MODE_HONOR = 2'd0;
    localparam logic [1:0] MODE_FILM  = 2'd1;
    localparam logic [1:0] MODE_RAW   = 2'd2;

    // Repeat codes
    localparam logic [1:0] CODE_DROP   = 2'd0;
    localparam logic [1:0] CODE_NORMAL = 2'd1;
    localparam logic [1:0] CODE_REPEAT = 2'd2;

    // Balance thresholds
    localparam logic signed [3:0] INIT_LIMIT = 4'sd3;
    localparam logic signed [3:0] LOCK_LIMIT = 4'sd5;

    localparam int IN_TDATA_WIDTH  = 8;
    localparam int OUT_TDATA_WIDTH = 112;

    typedef struct packed {
        logic       first_frame;
        logic [1:0] field_flags;
    } pic_t;

    typedef struct packed {
        logic [1:0]                  repeat_code;
        logic [1:0]                  store_passes;
        logic [2:0]                  frames_shown;
        logic [PORT_COUNT_WIDTH-1:0] shown_total;
        logic [PORT_COUNT_WIDTH-1:0] film_count;
        logic [PORT_COUNT_WIDTH-1:0] video_count;
        logic                        top_waiting;
        logic                        bottom_waiting;
    } result_t;

    typedef struct packed {
        logic top;
        logic bottom;
        logic [1:0] frames;
    } pend_t;

    // Store one field pair, then the optional extra field of a repeated
    // first field; count frames completed on the way.
    function automatic pend_t store_pair(input logic top_in, input logic bottom_in,
                                         input logic extra, input logic tff);
        pend_t r;
        r.top    = top_in & ~bottom_in;
        r.bottom = bottom_in | ~top_in | bottom_in;
        r.bottom = bottom_in;
        r.frames = 2'd1;
        if (extra)
        begin
            if (tff)
                r.top = 1'b1;
            else
                r.bottom = 1'b1;
            if (r.top && r.bottom)
            begin
                r.top    = 1'b0;
                r.bottom = 1'b0;
                r.frames = 2'd2;
            end
        end
        return r;
    endfunction

endpackage

/* design/telecine_field_cadence_tracker.sv */
`timescale 1ns / 1ps
// A request is registered in the input register; its result is registered in the output
// register that drives m_tdata.
// Throughput: one request per cycle unless m_tready stalls the output; a picture is
// stepped through the tracker state combinationally between the two registers.
// Reset (rst_n low, asynchronous): all cadence state, counters and valid flags
// clear; field_mode returns to 0 (honor pulldown flags).
module telecine_field_cadence_tracker
    import cft_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write: field_mode
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data,
    // Picture requests
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [IN_TDATA_WIDTH-1:0] s_tdata,  // [1:0] field_flags, rest zero
    input  logic        s_tuser,                // [0] first_frame
    // Results
    output logic        m_tvalid,
    input  logic        m_tready,
    // [1:0] repeat_code, [3:2] store_passes, [6:4] frames_shown,
    // [38:7] shown_total, [70:39] film_count, [102:71] video_count,
    // [103] top_waiting, [104] bottom_waiting, rest zero
    output logic [OUT_TDATA_WIDTH-1:0] m_tdata
);

    logic [1:0] field_mode_reg;
    logic       pic_valid;
    logic       advance;
    pic_t       pic_in;
    pic_t       pic_held;
    result_t    result;

    // Configuration is always ready; the user writes it only while idle, the block does not enforce it
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            field_mode_reg <= MODE_HONOR;
        else if (cfg_valid)
            field_mode_reg <= cfg_data;
    end

    assign pic_in.first_frame = s_tuser;
    assign pic_in.field_flags = s_tdata[1:0];

    // Hold the incoming picture
    cft_input_reg u_input_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .pic_in    (pic_in),
        .advance   (advance),
        .pic_valid (pic_valid),
        .pic_out   (pic_held)
    );

    // Advance cadence, balance and field pending state
    cft_engine u_engine (
        .clk        (clk),
        .rst_n      (rst_n),
        .advance    (advance),
        .pic        (pic_held),
        .field_mode (field_mode_reg),
        .result     (result)
    );

    // Capture the result and drive the output stream
    cft_output_reg u_output_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .pic_valid (pic_valid),
        .result    (result),
        .advance   (advance),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

/* design/cft_input_reg.sv */
`timescale 1ns / 1ps

module cft_input_reg
    import cft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  pic_t       pic_in,
    input  logic       advance,
    output logic       pic_valid,
    output pic_t       pic_out
);

    logic valid_reg;
    logic valid_next;
    pic_t pic_reg;

    // Take a new request when empty or when the held one moves on
    assign s_tready   = !valid_reg || advance;
    assign valid_next = (s_tvalid && s_tready) || (valid_reg && !advance);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            pic_reg <= pic_in;
    end

    assign pic_valid = valid_reg;
    assign pic_out   = pic_reg;

endmodule

/* design/cft_engine.sv */
`timescale 1ns / 1ps

module cft_engine
    import cft_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       advance,
    input  pic_t       pic,
    input  logic [1:0] field_mode,
    output result_t    result
);

    logic [COUNT_WIDTH-1:0] film_tally_reg, film_tally_next;
    logic [COUNT_WIDTH-1:0] video_tally_reg, video_tally_next;
    logic [COUNT_WIDTH-1:0] frames_reg, frames_next;
    logic [1:0]             prev_flags_reg;
    logic signed [3:0]      balance_reg, balance_next;
    logic                   locked_reg, locked_next;
    logic                   top_reg, top_next;
    logic                   bottom_reg, bottom_next;

    logic [COUNT_WIDTH-1:0] film_base, video_base, frames_base;
    logic signed [3:0]      balance_base, balance_sum, limit;
    logic                   locked_base;
    logic                   top_base, bottom_base;
    logic                   tff, rff_bit, extra;
    logic [1:0]             code, passes;
    pend_t                  pass1, pass2;
    logic [2:0]             shown;
    logic [COUNT_WIDTH+2:0] frames_sum;

    always_comb
    begin
        tff     = pic.field_flags[1];
        rff_bit = pic.field_flags[0];
        extra   = rff_bit && (field_mode != MODE_FILM) && (field_mode != MODE_RAW);

        // First picture of a sequence clears all tracking
        film_base    = pic.first_frame ? '0 : film_tally_reg;
        video_base   = pic.first_frame ? '0 : video_tally_reg;
        frames_base  = pic.first_frame ? '0 : frames_reg;
        balance_base = pic.first_frame ? 4'sd0 : balance_reg;
        locked_base  = pic.first_frame ? 1'b0 : locked_reg;
        top_base     = pic.first_frame ? 1'b0 : top_reg;
        bottom_base  = pic.first_frame ? 1'b0 : bottom_reg;

        film_tally_next  = film_base;
        video_tally_next = video_base;
        if (!pic.first_frame)
        begin
            if (pic.field_flags == prev_flags_reg + 2'd1)
                film_tally_next = (&film_base) ? film_base : film_base + 1'b1;
            else
                video_tally_next = (&video_base) ? video_base : video_base + 1'b1;
        end

        // Repeat-minus-plain balance
        balance_sum  = balance_base + (rff_bit ? 4'sd1 : -4'sd1);
        limit        = locked_base ? LOCK_LIMIT : INIT_LIMIT;
        balance_next = balance_sum;
        locked_next  = locked_base;
        code         = CODE_NORMAL;
        if (balance_sum <= -limit)
        begin
            balance_next = 4'sd0;
            locked_next  = 1'b1;
            code         = CODE_DROP;
        end
        else if (balance_sum >= limit)
        begin
            balance_next = 4'sd0;
            locked_next  = 1'b1;
            code         = CODE_REPEAT;
        end

        if (field_mode == MODE_FILM)
            passes = (code != CODE_DROP) ? 2'd1 : 2'd0;
        else
            passes = (code == CODE_REPEAT) ? 2'd2 : 2'd1;

        pass1 = store_pair(top_base, bottom_base, extra, tff);
        pass2 = store_pair(pass1.top, pass1.bottom, extra, tff);

        case (passes)
            2'd0:
            begin
                top_next    = top_base;
                bottom_next = bottom_base;
                shown       = 3'd0;
            end
            2'd1:
            begin
                top_next    = pass1.top;
                bottom_next = pass1.bottom;
                shown       = {1'b0, pass1.frames};
            end
            default:
            begin
                top_next    = pass2.top;
                bottom_next = pass2.bottom;
                shown       = {1'b0, pass1.frames} + {1'b0, pass2.frames};
            end
        endcase

        // Saturating add of up to four frames
        frames_sum = {3'b000, frames_base} + {{COUNT_WIDTH{1'b0}}, shown};
        if (|frames_sum[COUNT_WIDTH+2:COUNT_WIDTH])
            frames_next = '1;
        else
            frames_next = frames_sum[COUNT_WIDTH-1:0];

        result.repeat_code    = code;
        result.store_passes   = passes;
        result.frames_shown   = shown;
        result.shown_total    = PORT_COUNT_WIDTH'(frames_next);
        result.film_count     = PORT_COUNT_WIDTH'(film_tally_next);
        result.video_count    = PORT_COUNT_WIDTH'(video_tally_next);
        result.top_waiting    = top_next;
        result.bottom_waiting = bottom_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            film_tally_reg  <= '0;
            video_tally_reg <= '0;
            frames_reg      <= '0;
            prev_flags_reg  <= 2'd0;
            balance_reg     <= 4'sd0;
            locked_reg      <= 1'b0;
            top_reg         <= 1'b0;
            bottom_reg      <= 1'b0;
        end
        else if (advance)
        begin
            film_tally_reg  <= film_tally_next;
            video_tally_reg <= video_tally_next;
            frames_reg      <= frames_next;
            prev_flags_reg  <= pic.field_flags;
            balance_reg     <= balance_next;
            locked_reg      <= locked_next;
            top_reg         <= top_next;
            bottom_reg      <= bottom_next;
        end
    end

endmodule

/* design/cft_output_reg.sv */
`timescale 1ns / 1ps

module cft_output_reg
    import cft_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    pic_valid,
    input  result_t result,
    output logic    advance,
    output logic    m_tvalid,
    input  logic    m_tready,
    output logic [OUT_TDATA_WIDTH-1:0] m_tdata
);

    logic    valid_reg, valid_next;
    result_t res_reg;

    // Load when empty or when the held result is being taken
    assign advance    = pic_valid && (!valid_reg || m_tready);
    assign valid_next = advance || (valid_reg && !m_tready);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (advance)
            res_reg <= result;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = {7'b0000000,
                       res_reg.bottom_waiting,
                       res_reg.top_waiting,
                       res_reg.video_count,
                       res_reg.film_count,
                       res_reg.shown_total,
                       res_reg.frames_shown,
                       res_reg.store_passes,
                       res_reg.repeat_code};

endmodule

/* design/cft_checker.sv */
`timescale 1ns / 1ps

module cft_checker
    import cft_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [OUT_TDATA_WIDTH-1:0] m_tdata
);

    // Stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // Repeat code is never the unused value
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[1:0] != 2'd3)
        else $error("invalid repeat code");

    // Passes follow the repeat code
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[1:0] != CODE_NORMAL || m_tdata[3:2] == 2'd1) &&
                     (m_tdata[1:0] != CODE_DROP || m_tdata[3:2] <= 2'd1) &&
                     (m_tdata[1:0] != CODE_REPEAT || m_tdata[3:2] >= 2'd1))
        else $error("store passes inconsistent with repeat code");

    // Each stored pair completes one or two frames
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> ({1'b0, m_tdata[3:2]} <= m_tdata[6:4]) &&
                     (m_tdata[6:4] <= {m_tdata[3:2], 1'b0}))
        else $error("frames shown out of range for passes");

    // A complete pair never stays pending
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !(m_tdata[103] && m_tdata[104]))
        else $error("both fields left waiting");

endmodule

bind telecine_field_cadence_tracker cft_checker u_cft_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
